FILE: design/pop3_command_recognizer_defines.svh
// Assertion macros shared by the checker of the POP3 command recognizer.
`ifndef POP3_COMMAND_RECOGNIZER_DEFINES_SVH
`define POP3_COMMAND_RECOGNIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define POP3CR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pop3cr check failed");

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define POP3CR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pop3cr check failed");

`endif

FILE: design/pop3cr_pkg.sv
// Types, codes and the command name table of the POP3 command recognizer.
package pop3cr_pkg;

   // One client byte as it enters the block.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_in_chunk;
   } req_type;

   // One result item per client byte.
   typedef struct packed {
      logic       flush;
      logic       chunk_searching;
      logic       server_update;
      logic [1:0] server_expect;
   } rsp_type;

   // Line parser state, one-hot.
   typedef enum logic [2:0] {
      ST_SEARCH = 3'b001,
      ST_FIN    = 3'b010,
      ST_ARG    = 3'b100
   } status_type;

   // Candidate command picked by the first letter of a line.
   typedef enum logic [2:0] {
      CAND_NONE = 3'd0,
      CAND_CAPA = 3'd1,
      CAND_LIST = 3'd2,
      CAND_RETR = 3'd3,
      CAND_TOP  = 3'd4,
      CAND_UIDL = 3'd5
   } cmd_type;

   // Server response classes; RESP_HAS_ARG marks a command that takes an argument.
   typedef enum logic [1:0] {
      RESP_SINGLE  = 2'd0,
      RESP_MULTI   = 2'd1,
      RESP_DATA    = 2'd2,
      RESP_HAS_ARG = 2'd3
   } resp_type;

   // ASCII characters the parser looks for.
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   // Command names, first letter in the low byte, unused bytes zero.
   localparam logic [31:0] NAME_CAPA = 32'h4150_4143;
   localparam logic [31:0] NAME_LIST = 32'h5453_494C;
   localparam logic [31:0] NAME_RETR = 32'h5254_4552;
   localparam logic [31:0] NAME_TOP  = 32'h0050_4F54;
   localparam logic [31:0] NAME_UIDL = 32'h4C44_4955;

   // Letter of a command name at a position; zero past the end of the name.
   function automatic logic [7:0] name_letter(input cmd_type cmd, input logic [2:0] pos);
      logic [31:0] word;
      unique case (cmd)
         CAND_CAPA: word = NAME_CAPA;
         CAND_LIST: word = NAME_LIST;
         CAND_RETR: word = NAME_RETR;
         CAND_TOP:  word = NAME_TOP;
         CAND_UIDL: word = NAME_UIDL;
         default:   word = '0;
      endcase
      if (pos[2]) begin
         return 8'h00;
      end
      return word[{pos[1:0], 3'b000} +: 8];
   endfunction

   // ASCII a-z fold to A-Z; every other byte stays as it is.
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

endpackage

FILE: design/pop3_command_recognizer.sv
// A byte is first taken into the input register and then moves into the result
// register, which drives the outputs; a stall on the result side holds it in place.
// Throughput: one byte per cycle unless the result side stalls; the parser state is
// updated in the same cycle the result register is loaded, so each byte sees the state
// left by the last. Reset clears both valid flags and the parser state: searching, no
// command, letter position zero, single-line class. No clearing pass is needed.
module pop3_command_recognizer
   import pop3cr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // Pipeline registers.
   logic       in_valid_ff;
   req_type    in_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   // Parser state.
   status_type status_ff, status_in;
   cmd_type    cmd_ff, cmd_in;
   logic [2:0] pos_ff, pos_in;
   resp_type   resp_ff, resp_in;

   // Decode of the registered byte.
   logic [7:0] upper;
   logic [7:0] letter;
   logic       is_lf;
   logic       is_term;
   logic       is_digit;
   logic       out_ready;
   logic       advance;
   logic       flush;
   logic       upd;
   resp_type   expect_cls;

   // Handshake: the output register frees when empty or taken; the input stage
   // moves forward whenever the output register can take its item.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // Character classes of the byte at the head of the pipe.
   assign upper    = fold_upper(in_ff.byte_in);
   assign letter   = name_letter(cmd_ff, pos_ff);
   assign is_lf    = (in_ff.byte_in == CHAR_LF);
   assign is_term  = (in_ff.byte_in == CHAR_SPACE) || (in_ff.byte_in == CHAR_TAB) ||
                     (in_ff.byte_in == CHAR_CR) || is_lf;
   assign is_digit = (in_ff.byte_in >= CHAR_0) && (in_ff.byte_in <= CHAR_9);

   // Command recognition and the next parser state.
   always_comb begin
      status_in  = status_ff;
      cmd_in     = cmd_ff;
      pos_in     = pos_ff;
      resp_in    = resp_ff;
      flush      = 1'b0;
      upd        = 1'b0;
      expect_cls = RESP_SINGLE;
      unique case (status_ff)
         ST_SEARCH: begin
            if (cmd_ff == CAND_NONE) begin
               // First letter of the line picks the candidate.
               unique case (upper)
                  CHAR_C: begin
                     cmd_in  = CAND_CAPA;
                     resp_in = RESP_MULTI;
                     pos_in  = 3'd1;
                  end
                  CHAR_L: begin
                     cmd_in  = CAND_LIST;
                     resp_in = RESP_HAS_ARG;
                     pos_in  = 3'd1;
                  end
                  CHAR_R: begin
                     cmd_in  = CAND_RETR;
                     resp_in = RESP_DATA;
                     pos_in  = 3'd1;
                  end
                  CHAR_T: begin
                     cmd_in  = CAND_TOP;
                     resp_in = RESP_DATA;
                     pos_in  = 3'd1;
                  end
                  CHAR_U: begin
                     cmd_in  = CAND_UIDL;
                     resp_in = RESP_HAS_ARG;
                     pos_in  = 3'd1;
                  end
                  default: begin
                     status_in = ST_FIN;
                  end
               endcase
            end else if (letter == 8'h00 && is_term) begin
               // Full name followed by a separator ends the command.
               if (resp_ff == RESP_HAS_ARG) begin
                  status_in = ST_ARG;
                  if (is_lf) begin
                     upd        = 1'b1;
                     expect_cls = RESP_MULTI;
                  end
               end else begin
                  status_in  = ST_FIN;
                  upd        = 1'b1;
                  expect_cls = resp_ff;
               end
            end else if (letter != 8'h00 && upper == letter) begin
               pos_in = pos_ff + 3'd1;
            end else begin
               status_in = ST_FIN;
            end
            flush = is_lf;
         end
         ST_ARG: begin
            // A digit argument keeps the single-line default; a bare LF asks for a list.
            if (is_lf) begin
               flush      = 1'b1;
               upd        = 1'b1;
               expect_cls = RESP_MULTI;
            end else if (is_digit) begin
               status_in = ST_FIN;
            end
         end
         default: begin
            flush = is_lf;
         end
      endcase
      // LF ends the line and re-arms the recognizer.
      if (flush) begin
         status_in = ST_SEARCH;
         cmd_in    = CAND_NONE;
         pos_in    = 3'd0;
      end
   end

   // Result item built from the decode.
   always_comb begin
      out_in.flush           = flush;
      out_in.chunk_searching = in_ff.last_in_chunk && !flush;
      out_in.server_update   = upd;
      out_in.server_expect   = expect_cls;
      out_valid_in           = advance || (out_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff    <= ST_SEARCH;
         cmd_ff       <= CAND_NONE;
         pos_ff       <= 3'd0;
         resp_ff      <= RESP_SINGLE;
      end else begin
         out_valid_ff <= out_valid_in;
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            status_ff <= status_in;
            cmd_ff    <= cmd_in;
            pos_ff    <= pos_in;
            resp_ff   <= resp_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: design/pop3cr_checker.sv
// Port-level checker of the POP3 command recognizer and its bind.
`include "pop3_command_recognizer_defines.svh"

module pop3cr_checker
   import pop3cr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // Result fields under test; they mean something only with rsp_valid.
   logic       upd;
   logic [1:0] cls;
   logic       flushed;
   logic       searching;

   assign upd       = rsp_payload.server_update;
   assign cls       = rsp_payload.server_expect;
   assign flushed   = rsp_payload.flush;
   assign searching = rsp_payload.chunk_searching;

   // A stalled input item holds still until it is accepted.
   `POP3CR_ASSERT_NEXT(req_hold_chk, req_valid && req_stall, req_valid && $stable(req_payload))

   // A waiting result item holds still until it is taken.
   `POP3CR_ASSERT_NEXT(rsp_hold_chk, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // The class field is zero unless the server class is being set.
   `POP3CR_ASSERT_NOW(expect_zero_chk, rsp_valid && !upd, cls == RESP_SINGLE)

   // An update always announces a multi-line or data response.
   `POP3CR_ASSERT_NOW(update_class_chk, rsp_valid && upd, cls == RESP_MULTI || cls == RESP_DATA)

   // A flushed line never reports the segment as still searching.
   `POP3CR_ASSERT_NOW(flush_search_chk, rsp_valid && flushed, !searching)

endmodule

bind pop3_command_recognizer pop3cr_checker u_pop3cr_checker (.*);

FILE: tb/pop3_command_recognizer_tb.sv
// Self-checking testbench that streams client bytes into the POP3 command recognizer.
`timescale 1ns / 100ps

module pop3_command_recognizer_tb;
   import pop3cr_pkg::*;

   // One row of the directed table: the byte sent and, where given, its known result.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the line parser.
   status_type line_state = ST_SEARCH;
   cmd_type    line_cmd = CAND_NONE;
   logic [2:0] letter_idx = 3'd0;
   resp_type   line_class = RESP_SINGLE;

   rsp_type      expected_replies[$];
   plan_row_type directed_rows[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_left = 0;
   int bytes_sent = 0;
   int replies_seen = 0;
   int updates_seen = 0;
   int flushes_seen = 0;
   int fault_count = 0;

   pop3_command_recognizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // 12 ns clock period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Upper-case only ASCII letters.
   function automatic logic [7:0] upper_case(input logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

   // Letter of a command's name at a position, zero past its end.
   function automatic logic [7:0] spelled_letter(input cmd_type c, input logic [2:0] pos);
      string word;
      case (c)
         CAND_CAPA: word = "CAPA";
         CAND_LIST: word = "LIST";
         CAND_RETR: word = "RETR";
         CAND_TOP:  word = "TOP";
         CAND_UIDL: word = "UIDL";
         default:   word = "";
      endcase
      if (pos >= word.len()) begin
         return 8'h00;
      end
      return word[pos];
   endfunction

   // Advances the shadow parser by one byte and returns the result it should give.
   function automatic rsp_type parse_client_byte(input req_type it);
      rsp_type    r;
      logic [7:0] ch;
      logic [7:0] want;
      logic       lf;
      logic       term;
      r = '0;
      ch = it.byte_in;
      lf = (ch == CHAR_LF);
      case (line_state)
         ST_SEARCH: begin
            if (line_cmd == CAND_NONE) begin
               // The first letter of the line picks the candidate command.
               case (upper_case(ch))
                  CHAR_C: begin
                     line_cmd = CAND_CAPA;
                     line_class = RESP_MULTI;
                  end
                  CHAR_L: begin
                     line_cmd = CAND_LIST;
                     line_class = RESP_HAS_ARG;
                  end
                  CHAR_R: begin
                     line_cmd = CAND_RETR;
                     line_class = RESP_DATA;
                  end
                  CHAR_T: begin
                     line_cmd = CAND_TOP;
                     line_class = RESP_DATA;
                  end
                  CHAR_U: begin
                     line_cmd = CAND_UIDL;
                     line_class = RESP_HAS_ARG;
                  end
                  default: begin
                     line_state = ST_FIN;
                  end
               endcase
               if (line_cmd != CAND_NONE) begin
                  letter_idx = 3'd1;
               end
            end else begin
               // Match the rest of the name, then look for a terminator.
               want = spelled_letter(line_cmd, letter_idx);
               term = (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_CR || lf);
               if (want == 8'h00 && term) begin
                  if (line_class == RESP_HAS_ARG) begin
                     line_state = ST_ARG;
                     if (lf) begin
                        r.server_update = 1'b1;
                        r.server_expect = RESP_MULTI;
                     end
                  end else begin
                     line_state = ST_FIN;
                     r.server_update = 1'b1;
                     r.server_expect = line_class;
                  end
               end else if (want != 8'h00 && upper_case(ch) == want) begin
                  letter_idx = letter_idx + 3'd1;
               end else begin
                  line_state = ST_FIN;
               end
            end
            r.flush = lf;
         end
         ST_ARG: begin
            // A bare LF means a listing; a digit means a single line.
            if (lf) begin
               r.flush = 1'b1;
               r.server_update = 1'b1;
               r.server_expect = RESP_MULTI;
            end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
               line_state = ST_FIN;
            end
         end
         default: begin
            r.flush = lf;
         end
      endcase
      if (r.flush) begin
         line_state = ST_SEARCH;
         line_cmd = CAND_NONE;
         letter_idx = 3'd0;
      end
      r.chunk_searching = it.last_in_chunk && !r.flush;
      return r;
   endfunction

   // Adds a row to the directed table.
   function automatic void plan(input logic [7:0] ch, input logic last, input logic typed,
                                input rsp_type want);
      plan_row_type row;
      row.item.byte_in = ch;
      row.item.last_in_chunk = last;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   // Offers one item, called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input req_type it, input logic typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = parse_client_byte(it);
      expected_replies.push_back(typed ? want : predicted);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Sends one byte with a random end-of-segment mark.
   task automatic send_byte(input logic [7:0] ch);
      req_type it;
      it.byte_in = ch;
      it.last_in_chunk = ($urandom_range(7) == 0);
      send_item(it, 1'b0, '0);
   endtask

   // One random client line: mostly commands in mixed case, some broken, some noise.
   task automatic send_random_line();
      string      word;
      int         roll;
      int         i;
      logic [7:0] ch;
      roll = $urandom_range(99);
      if (roll < 12) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
         if ($urandom_range(3) != 0) begin
            send_byte(CHAR_LF);
         end
      end else begin
         case ($urandom_range(4))
            0: word = "CAPA";
            1: word = "LIST";
            2: word = "RETR";
            3: word = "TOP";
            default: word = "UIDL";
         endcase
         for (i = 0; i < word.len(); i++) begin
            ch = word[i];
            if ($urandom_range(1) != 0) begin
               ch = ch + CASE_DIFF;
            end
            // Now and then a letter is replaced by an arbitrary byte.
            if ($urandom_range(24) == 0) begin
               ch = 8'($urandom_range(255));
            end
            send_byte(ch);
         end
         if ($urandom_range(15) == 0) begin
            send_byte(CHAR_C + 8'($urandom_range(20)));
         end
         case ($urandom_range(3))
            0: ch = CHAR_SPACE;
            1: ch = CHAR_TAB;
            2: ch = CHAR_CR;
            default: ch = CHAR_LF;
         endcase
         send_byte(ch);
         if (ch != CHAR_LF) begin
            // Optional argument: junk, digits or nothing, then the line end.
            roll = $urandom_range(9);
            if (roll < 2) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
            if (roll < 6) begin
               repeat ($urandom_range(1, 3)) send_byte(CHAR_0 + 8'($urandom_range(9)));
            end
            if ($urandom_range(1) != 0) begin
               send_byte(CHAR_CR);
            end
            send_byte(CHAR_LF);
         end
      end
   endtask

   // Stops offering items until every expected result has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Result side stall: random, or held for a counted stretch on request.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare every accepted result item with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected result item %b with nothing expected", rsp_payload);
            fault_count++;
         end else begin
            want = expected_replies.pop_front();
            replies_seen++;
            if (rsp_payload.server_update) begin
               updates_seen++;
            end
            if (rsp_payload.flush) begin
               flushes_seen++;
            end
            if (rsp_payload.flush !== want.flush) begin
               $error("flush: expected %0b, got %0b", want.flush, rsp_payload.flush);
               fault_count++;
            end
            if (rsp_payload.chunk_searching !== want.chunk_searching) begin
               $error("chunk_searching: expected %0b, got %0b",
                      want.chunk_searching, rsp_payload.chunk_searching);
               fault_count++;
            end
            if (rsp_payload.server_update !== want.server_update) begin
               $error("server_update: expected %0b, got %0b",
                      want.server_update, rsp_payload.server_update);
               fault_count++;
            end
            if (rsp_payload.server_expect !== want.server_expect) begin
               $error("server_expect: expected %0d, got %0d",
                      want.server_expect, rsp_payload.server_expect);
               fault_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Main sequence.
   initial begin
      int row_index;
      int phase_target;

      // Unknown first letter, then LF re-arms; both bytes carry the segment mark.
      plan(8'h00, 1'b1, 1'b1, {1'b0, 1'b1, 1'b0, RESP_SINGLE});
      plan(CHAR_LF, 1'b1, 1'b1, {1'b1, 1'b0, 1'b0, RESP_SINGLE});
      // RETR in mixed case ended by a blank gives the data class.
      plan("r", 1'b0, 1'b0, '0);
      plan("E", 1'b1, 1'b0, '0);
      plan("t", 1'b0, 1'b0, '0);
      plan("R", 1'b0, 1'b0, '0);
      plan(CHAR_SPACE, 1'b0, 1'b1, {1'b0, 1'b0, 1'b1, RESP_DATA});
      plan(CHAR_LF, 1'b0, 1'b0, '0);
      // LIST ended right by LF answers with a listing.
      plan("L", 1'b0, 1'b0, '0);
      plan("i", 1'b0, 1'b0, '0);
      plan("s", 1'b0, 1'b0, '0);
      plan("t", 1'b0, 1'b0, '0);
      plan(CHAR_LF, 1'b1, 1'b1, {1'b1, 1'b0, 1'b1, RESP_MULTI});
      // UIDL with a tab, a byte that is ignored, then a digit argument.
      plan("U", 1'b0, 1'b0, '0);
      plan("i", 1'b0, 1'b0, '0);
      plan("D", 1'b0, 1'b0, '0);
      plan("l", 1'b0, 1'b0, '0);
      plan(CHAR_TAB, 1'b0, 1'b0, '0);
      plan(8'hFF, 1'b1, 1'b0, '0);
      plan(CHAR_0, 1'b0, 1'b0, '0);
      plan(CHAR_LF, 1'b0, 1'b0, '0);
      // CAPA ended by CR.
      plan("c", 1'b0, 1'b0, '0);
      plan("A", 1'b0, 1'b0, '0);
      plan("p", 1'b0, 1'b0, '0);
      plan("a", 1'b0, 1'b0, '0);
      plan(CHAR_CR, 1'b0, 1'b0, '0);
      plan(CHAR_LF, 1'b0, 1'b0, '0);
      // TOP followed by an extra letter is not a command.
      plan("T", 1'b0, 1'b0, '0);
      plan("o", 1'b0, 1'b0, '0);
      plan("P", 1'b0, 1'b0, '0);
      plan("s", 1'b0, 1'b0, '0);
      plan(CHAR_LF, 1'b1, 1'b0, '0);

      send_idle_pct = 18;
      recv_idle_pct = 69;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row_index = 0; row_index < directed_rows.size(); row_index++) begin
         send_item(directed_rows[row_index].item, directed_rows[row_index].typed,
                   directed_rows[row_index].want);
      end

      // Random lines: sender idles little, receiver stalls often.
      phase_target = bytes_sent + 200;
      while (bytes_sent < phase_target) begin
         send_random_line();
      end
      wait_until_drained();

      // Sender idles often, receiver rarely.
      send_idle_pct = 69;
      recv_idle_pct = 18;
      phase_target = bytes_sent + 200;
      while (bytes_sent < phase_target) begin
         send_random_line();
      end
      wait_until_drained();

      // No idling; a long result hold-off first makes the block back up to its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_hold_left = 60;
      phase_target = bytes_sent + 200;
      while (bytes_sent < phase_target) begin
         send_random_line();
      end
      wait_until_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d client bytes: directed lines, then random lines under three stall mixes",
               bytes_sent);
      $display("and one long result hold-off; %0d results checked, %0d class updates, %0d flushes.",
               replies_seen, updates_seen, flushes_seen);
      if (fault_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
